>>> src/ucl_pkg.sv
// Shared types and constants for the UART command line recognizer.
// No dependencies; compiled first.
`default_nettype none

package ucl_pkg;

    // Line buffer capacity; a line is full at LINE_CAPACITY-1 characters.
    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    localparam int NUM_WORDS = 7;
    localparam int WORD_MAX  = 6;
    localparam int CHAR_W    = $clog2(WORD_MAX);

    localparam logic [NUM_WORDS-1:0] ALL_CANDIDATES = '1;

    typedef enum logic [1:0] {
        OP_OPEN = 2'd0,
        OP_BYTE = 2'd1,
        OP_TICK = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_TIMEOUT  = 3'd4
    } t_status;

    localparam logic [2:0] CMD_NONE = 3'd0;

    localparam logic [7:0] CHAR_CR        = 8'd13;
    localparam logic [7:0] CHAR_LF        = 8'd10;
    localparam logic [7:0] PRINTABLE_LOW  = 8'd32;
    localparam logic [7:0] PRINTABLE_HIGH = 8'd126;

    // Command words; entry k is command k+1. Short words are zero padded.
    localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_MAX] = '{
        '{"A", "U", "T", "O", 8'h00, 8'h00},
        '{"B", "O", "O", "T", " ", "A"},
        '{"B", "O", "O", "T", " ", "B"},
        '{"S", "A", "F", "E", " ", "A"},
        '{"S", "A", "F", "E", " ", "B"},
        '{"U", "P", "D", "A", "T", "E"},
        '{"S", "T", "A", "Y", 8'h00, 8'h00}
    };

    localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
        3'd4, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4
    };

endpackage

`default_nettype wire

>>> src/ucl_if.sv
// Valid/ready channel interfaces for the command line recognizer.
// Depends on ucl_pkg for opcode and status types.
`default_nettype none

interface ucl_in_if import ucl_pkg::*; ();
    logic       valid;
    logic       ready;
    t_opcode    opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface ucl_out_if import ucl_pkg::*; ();
    logic       valid;
    logic       ready;
    t_status    status;
    logic [2:0] command;
    logic       window_active;

    modport source (output valid, output status, output command, output window_active,
                    input ready);
    modport sink   (input valid, input status, input command, input window_active,
                    output ready);
endinterface

`default_nettype wire

>>> src/uart_command_line_recognizer.sv
// A result is valid in the cycle after acceptance; the output register drains
// while the next item enters. Throughput: one item per cycle unless o_out.ready stalls.
// The only loop is the state update (window, tick count, line length, match mask).
// Reset (i_rst_n low, synchronous): window closed, counters cleared, mask all ones,
// timeout register 1000, output register empty.
`default_nettype none

module uart_command_line_recognizer import ucl_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ucl_in_if.sink      i_in,
    ucl_out_if.source   o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // Configuration: one register, the window timeout in ticks, at byte address 0.
    // Byte lanes inside a word are not decoded.
    // ---------------------------------------------------------------
    localparam logic REG_TIMEOUT = 1'b0;

    logic [31:0] r_timeout;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? r_timeout : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 32'd1000;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
            r_timeout <= pwdata;
        end
    end

    // ---------------------------------------------------------------
    // Recognizer state
    // ---------------------------------------------------------------
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

    logic                 r_open,    n_open;
    logic [31:0]          r_elapsed, n_elapsed;
    logic [LEN_W-1:0]     r_len,     n_len;
    logic [NUM_WORDS-1:0] r_mask,    n_mask;

    // Output register
    logic       r_out_valid;
    t_status    r_status,  n_status;
    logic [2:0] r_command, n_command;
    logic       r_active;

    logic in_fire;
    logic is_eol;
    logic is_print;
    logic [2:0] match_cmd;

    // Take a new item whenever the output slot is empty or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    assign is_eol   = (i_in.data_byte == CHAR_CR) || (i_in.data_byte == CHAR_LF);
    assign is_print = (i_in.data_byte >= PRINTABLE_LOW) && (i_in.data_byte <= PRINTABLE_HIGH);

    // Lowest-numbered surviving word whose length equals the line length.
    always_comb begin
        match_cmd = CMD_NONE;
        for (int k = NUM_WORDS - 1; k >= 0; k--) begin
            if (r_mask[k] && r_len == LEN_W'(WORD_LEN[k])) begin
                match_cmd = 3'(k + 1);
            end
        end
    end

    always_comb begin
        n_open    = r_open;
        n_elapsed = r_elapsed;
        n_len     = r_len;
        n_mask    = r_mask;
        n_status  = ST_NONE;
        n_command = CMD_NONE;

        case (i_in.opcode)
            OP_OPEN: begin
                n_open    = 1'b1;
                n_elapsed = 32'd0;
                n_len     = '0;
                n_mask    = ALL_CANDIDATES;
                if (r_timeout == 32'd0) begin
                    n_open   = 1'b0;
                    n_status = ST_TIMEOUT;
                end
            end
            OP_BYTE: begin
                if (r_open) begin
                    if (is_eol) begin
                        // empty line end is ignored
                        if (r_len != '0) begin
                            n_command = match_cmd;
                            if (match_cmd != CMD_NONE) begin
                                n_status = ST_ACCEPT;
                                n_open   = 1'b0;
                            end else begin
                                n_status = ST_UNKNOWN;
                            end
                            n_len  = '0;
                            n_mask = ALL_CANDIDATES;
                        end
                    end else if (r_len != LEN_LAST) begin
                        if (is_print) begin
                            for (int k = 0; k < NUM_WORDS; k++) begin
                                // the length test keeps the char index below WORD_MAX
                                if (!(r_len < LEN_W'(WORD_LEN[k]) &&
                                      WORD_TEXT[k][r_len[CHAR_W-1:0]] == i_in.data_byte)) begin
                                    n_mask[k] = 1'b0;
                                end
                            end
                            n_len = r_len + 1'b1;
                        end
                    end else begin
                        // line full: drop the byte and start over
                        n_len    = '0;
                        n_mask   = ALL_CANDIDATES;
                        n_status = ST_TOO_LONG;
                    end
                end
            end
            OP_TICK: begin
                if (r_open) begin
                    if (r_elapsed != 32'hFFFF_FFFF) begin
                        n_elapsed = r_elapsed + 32'd1;
                    end
                    if (n_elapsed >= r_timeout) begin
                        n_open   = 1'b0;
                        n_status = ST_TIMEOUT;
                    end
                end
            end
            default: begin
                // unused opcode: no state change, status none
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_elapsed   <= 32'd0;
            r_len       <= '0;
            r_mask      <= ALL_CANDIDATES;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_open      <= n_open;
                r_elapsed   <= n_elapsed;
                r_len       <= n_len;
                r_mask      <= n_mask;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status  <= n_status;
            r_command <= n_command;
            r_active  <= n_open;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.command       = r_command;
    assign o_out.window_active = r_active;

`ifndef SYNTHESIS
    // Every accepted item leaves a result in the output register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out.valid)
        else $error("accepted item produced no result");

    // A command code appears exactly with an accepted command.
    a_command_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.command != CMD_NONE) == (o_out.status == ST_ACCEPT)))
        else $error("command code and status disagree");

    // Accept and timeout both close the window.
    a_close_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_ACCEPT || o_out.status == ST_TIMEOUT)
        |-> !o_out.window_active)
        else $error("window still open after accept or timeout");

    // Window state reported matches the internal state it was taken from.
    a_active_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (o_out.window_active == r_open))
        else $error("reported window state differs from internal state");
`endif

endmodule

`default_nettype wire
